[hw/rtl/ats_pkg.sv]
// ats_pkg: shared constants, types and codes for the active tween stepper.
// Used by ats_front, ats_cmd_fifo, ats_slot_ram, ats_back and the top level.
`timescale 1ns / 1ps
`default_nettype none
package ats_pkg;

  localparam int SLOTS = 16;
  localparam int IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int CNT_W = $clog2(SLOTS + 1);
  localparam int FIFO_DEPTH = 2;

  localparam logic [15:0] PHASE_GATE_MASK = 16'hff00;

  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_TICK = 1'b1
  } cmd_kind_t;

  typedef enum logic [1:0] {
    RES_ADD_OK = 2'd0,
    RES_FULL   = 2'd1,
    RES_WRITE  = 2'd2
  } res_status_t;

  typedef struct packed {
    cmd_kind_t   kind;
    logic [14:0] count;
    logic [15:0] addr;
    logic [31:0] value;
    logic [31:0] delta;
  } cmd_t;

  typedef struct packed {
    logic [15:0] count;
    logic [15:0] target;
    logic [31:0] accum;
    logic [31:0] delta;
  } slot_t;

  typedef struct packed {
    logic             we;
    logic [IDX_W-1:0] waddr;
    slot_t            wdata;
    logic             re_a;
    logic [IDX_W-1:0] raddr_a;
    logic             re_b;
    logic [IDX_W-1:0] raddr_b;
  } ram_req_t;

endpackage
`default_nettype wire

[hw/rtl/active_tween_stepper.sv]
// Active tween stepper. Add: one result beat per add, registered after the queue. Tick: one write
// beat per active tween, one per cycle once the walk has begun; the back end takes no new command
// while it walks the table (one slot per cycle on the RAM ports).
// Gated ticks never reach the back end. A two-deep queue decouples intake; busy means it is full.
// Reset (synchronous, rst_n low) empties the queue and the table; slot RAM is not cleared.
`timescale 1ns / 1ps
`default_nettype none
module active_tween_stepper (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               start,
  output logic                    busy,
  input  wire logic               in_kind,
  input  wire logic [15:0]        in_phase,
  input  wire logic [14:0]        in_count_init,
  input  wire logic [15:0]        in_dest_addr,
  input  wire logic [31:0]        in_start_value,
  input  wire logic signed [31:0] in_delta,
  output logic                    out_valid,
  output logic [1:0]              out_status,
  output logic [15:0]             out_write_addr,
  output logic signed [15:0]      out_write_value,
  output logic                    out_expired,
  output logic                    out_last
);
  import ats_pkg::*;

  logic        fifo_full;
  logic        fifo_valid;
  logic        push;
  logic        pop;
  cmd_t        push_cmd;
  cmd_t        head;
  ram_req_t    ram_req;
  slot_t       rd_a;
  slot_t       rd_b;
  logic [15:0] write_value;

  ats_front u_front (
    .start          (start),
    .busy           (busy),
    .in_kind        (in_kind),
    .in_phase       (in_phase),
    .in_count_init  (in_count_init),
    .in_dest_addr   (in_dest_addr),
    .in_start_value (in_start_value),
    .in_delta       ($unsigned(in_delta)),
    .fifo_full      (fifo_full),
    .push           (push),
    .push_cmd       (push_cmd)
  );

  ats_cmd_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .full     (fifo_full),
    .valid    (fifo_valid),
    .head     (head)
  );

  ats_slot_ram u_ram (
    .clk  (clk),
    .req  (ram_req),
    .rd_a (rd_a),
    .rd_b (rd_b)
  );

  ats_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .fifo_valid      (fifo_valid),
    .head            (head),
    .pop             (pop),
    .ram_req         (ram_req),
    .rd_a            (rd_a),
    .rd_b            (rd_b),
    .out_valid       (out_valid),
    .out_status      (out_status),
    .out_write_addr  (out_write_addr),
    .out_write_value (write_value),
    .out_expired     (out_expired),
    .out_last        (out_last)
  );

  assign out_write_value = $signed(write_value);

endmodule
`default_nettype wire

[hw/rtl/ats_front.sv]
// ats_front: accepts input beats, classifies them and drops gated ticks.
// Depends on ats_pkg; feeds ats_cmd_fifo.
`timescale 1ns / 1ps
`default_nettype none
module ats_front (
  input  wire logic          start,
  output logic               busy,
  input  wire logic          in_kind,
  input  wire logic [15:0]   in_phase,
  input  wire logic [14:0]   in_count_init,
  input  wire logic [15:0]   in_dest_addr,
  input  wire logic [31:0]   in_start_value,
  input  wire logic [31:0]   in_delta,
  input  wire logic          fifo_full,
  output logic               push,
  output ats_pkg::cmd_t      push_cmd
);
  import ats_pkg::*;

  logic accept;
  logic gated;

  assign busy   = fifo_full;
  assign accept = start && !fifo_full;
  // a tick with a nonzero phase high byte does nothing at all
  assign gated  = (cmd_kind_t'(in_kind) == CMD_TICK) && ((in_phase & PHASE_GATE_MASK) != 16'd0);
  assign push   = accept && !gated;

  always_comb begin
    push_cmd.kind  = cmd_kind_t'(in_kind);
    push_cmd.count = in_count_init;
    push_cmd.addr  = in_dest_addr;
    push_cmd.value = in_start_value;
    push_cmd.delta = in_delta;
  end

endmodule
`default_nettype wire

[hw/rtl/ats_cmd_fifo.sv]
// ats_cmd_fifo: two-entry command queue between front and back.
// Depends on ats_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ats_cmd_fifo (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          push,
  input  wire ats_pkg::cmd_t push_cmd,
  input  wire logic          pop,
  output logic               full,
  output logic               valid,
  output ats_pkg::cmd_t      head
);
  import ats_pkg::*;

  cmd_t       mem_r [FIFO_DEPTH];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full  = (fill_r == 2'(FIFO_DEPTH));
  assign valid = (fill_r != 2'd0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? ~wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? ~rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ats_slot_ram.sv]
// ats_slot_ram: tween slot memory, one write port, two registered read ports.
// Depends on ats_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ats_slot_ram (
  input  wire logic              clk,
  input  wire ats_pkg::ram_req_t req,
  output ats_pkg::slot_t         rd_a,
  output ats_pkg::slot_t         rd_b
);
  import ats_pkg::*;

  slot_t mem [SLOTS];
  slot_t rd_a_r;
  slot_t rd_b_r;

  assign rd_a = rd_a_r;
  assign rd_b = rd_b_r;

  always_ff @(posedge clk) begin
    if (req.we) begin
      mem[req.waddr] <= req.wdata;
    end
    if (req.re_a) begin
      rd_a_r <= mem[req.raddr_a];
    end
    if (req.re_b) begin
      rd_b_r <= mem[req.raddr_b];
    end
  end

endmodule
`default_nettype wire

[hw/rtl/ats_back.sv]
// ats_back: executes queued commands; appends tweens and walks the table on ticks.
// Depends on ats_pkg; drives ats_slot_ram and the result registers.
`timescale 1ns / 1ps
`default_nettype none
module ats_back (
  input  wire logic          clk,
  input  wire logic          rst_n,
  input  wire logic          fifo_valid,
  input  wire ats_pkg::cmd_t head,
  output logic               pop,
  output ats_pkg::ram_req_t  ram_req,
  input  wire ats_pkg::slot_t rd_a,
  input  wire ats_pkg::slot_t rd_b,
  output logic               out_valid,
  output logic [1:0]         out_status,
  output logic [15:0]        out_write_addr,
  output logic [15:0]        out_write_value,
  output logic               out_expired,
  output logic               out_last
);
  import ats_pkg::*;

  typedef enum logic {
    S_IDLE,
    S_WALK
  } state_t;

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] total_r, total_nxt;
  logic [IDX_W-1:0] idx_r, idx_nxt;
  // cur: slot at idx, lst: slot at total-1; either fresh from RAM or held
  logic             cur_mem_r, cur_mem_nxt;
  logic             lst_mem_r, lst_mem_nxt;
  slot_t            cur_hold_r, cur_hold_nxt;
  slot_t            lst_hold_r, lst_hold_nxt;
  logic             valid_r, valid_nxt;
  res_status_t      status_r, status_nxt;
  logic [15:0]      addr_r, addr_nxt;
  logic [15:0]      value_r, value_nxt;
  logic             expired_r, expired_nxt;
  logic             last_r, last_nxt;

  slot_t            cur, lst, cur_upd;
  logic [15:0]      cnt_dec;
  logic             gone;
  logic             cont;
  logic             full;
  logic [CNT_W-1:0] new_last;

  assign cur      = cur_mem_r ? rd_a : cur_hold_r;
  assign lst      = lst_mem_r ? rd_b : lst_hold_r;
  assign cnt_dec  = cur.count - 16'd1;
  assign gone     = cnt_dec[15];
  // same test whether the slot stays or is replaced by the last one
  assign cont     = (CNT_W'(idx_r) + CNT_W'(1)) < total_r;
  assign full     = (total_r == CNT_W'(SLOTS));
  assign new_last = total_r - CNT_W'(2);

  always_comb begin
    cur_upd        = cur;
    cur_upd.count  = cnt_dec;
    cur_upd.accum  = cur.accum + cur.delta;
  end

  always_comb begin
    state_nxt    = state_r;
    total_nxt    = total_r;
    idx_nxt      = idx_r;
    cur_mem_nxt  = cur_mem_r;
    lst_mem_nxt  = lst_mem_r;
    cur_hold_nxt = cur;
    lst_hold_nxt = lst;
    valid_nxt    = 1'b0;
    status_nxt   = RES_ADD_OK;
    addr_nxt     = 16'd0;
    value_nxt    = 16'd0;
    expired_nxt  = 1'b0;
    last_nxt     = 1'b0;
    pop          = 1'b0;
    ram_req      = '0;

    case (state_r)
      S_IDLE: begin
        if (fifo_valid) begin
          pop = 1'b1;
          if (head.kind == CMD_ADD) begin
            valid_nxt = 1'b1;
            last_nxt  = 1'b1;
            if (full) begin
              status_nxt = RES_FULL;
            end else begin
              ram_req.we           = 1'b1;
              ram_req.waddr        = total_r[IDX_W-1:0];
              ram_req.wdata.count  = {1'b0, head.count};
              ram_req.wdata.target = head.addr;
              ram_req.wdata.accum  = head.value;
              ram_req.wdata.delta  = head.delta;
              total_nxt            = total_r + CNT_W'(1);
            end
          end else if (total_r != '0) begin
            ram_req.re_a    = 1'b1;
            ram_req.raddr_a = '0;
            ram_req.re_b    = 1'b1;
            ram_req.raddr_b = IDX_W'(total_r - CNT_W'(1));
            idx_nxt         = '0;
            cur_mem_nxt     = 1'b1;
            lst_mem_nxt     = 1'b1;
            state_nxt       = S_WALK;
          end
        end
      end
      S_WALK: begin
        valid_nxt     = 1'b1;
        status_nxt    = RES_WRITE;
        addr_nxt      = cur.target;
        value_nxt     = cur.accum[31:16];
        expired_nxt   = gone;
        last_nxt      = !cont;
        ram_req.we    = 1'b1;
        ram_req.waddr = idx_r;
        if (gone) begin
          ram_req.wdata = lst;
          total_nxt     = total_r - CNT_W'(1);
          cur_hold_nxt  = lst;
          cur_mem_nxt   = 1'b0;
          // new last slot is the one being overwritten right now: keep the copy
          if (new_last == CNT_W'(idx_r)) begin
            lst_mem_nxt = 1'b0;
          end else begin
            ram_req.re_b    = 1'b1;
            ram_req.raddr_b = new_last[IDX_W-1:0];
            lst_mem_nxt     = 1'b1;
          end
        end else begin
          ram_req.wdata   = cur_upd;
          idx_nxt         = IDX_W'(CNT_W'(idx_r) + CNT_W'(1));
          ram_req.re_a    = 1'b1;
          ram_req.raddr_a = IDX_W'(CNT_W'(idx_r) + CNT_W'(1));
          cur_mem_nxt     = 1'b1;
          lst_mem_nxt     = 1'b0;
        end
        if (!cont) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      total_r   <= '0;
      valid_r   <= 1'b0;
      cur_mem_r <= 1'b0;
      lst_mem_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      total_r   <= total_nxt;
      valid_r   <= valid_nxt;
      cur_mem_r <= cur_mem_nxt;
      lst_mem_r <= lst_mem_nxt;
    end
    idx_r      <= idx_nxt;
    cur_hold_r <= cur_hold_nxt;
    lst_hold_r <= lst_hold_nxt;
    status_r   <= status_nxt;
    addr_r     <= addr_nxt;
    value_r    <= value_nxt;
    expired_r  <= expired_nxt;
    last_r     <= last_nxt;
  end

  assign out_valid       = valid_r;
  assign out_status      = status_r;
  assign out_write_addr  = addr_r;
  assign out_write_value = value_r;
  assign out_expired     = expired_r;
  assign out_last        = last_r;

  a_total_bound: assert property (@(posedge clk) disable iff (!rst_n)
    total_r <= CNT_W'(SLOTS))
    else $error("active total beyond slot count");

  a_walk_emits: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |=> valid_r && status_r == RES_WRITE)
    else $error("walk step without a write beat");

  a_full_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE && fifo_valid && head.kind == CMD_ADD && full) |=>
      (total_r == $past(total_r) && status_r == RES_FULL))
    else $error("full add changed the table");

  a_expire_drops: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_WALK && gone) |=> total_r == $past(total_r) - CNT_W'(1))
    else $error("expired tween not removed");

  a_no_pop_walk: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_WALK |-> !pop)
    else $error("queue popped during walk");

endmodule
`default_nettype wire
